// File: hw/rtl/sawlc_pkg.sv
// Package for the set-associative write-back LRU cache.
// Item structs, operation and result codes, default geometry. No dependencies.
`timescale 1ns / 1ps
package sawlc_pkg;

  localparam int unsigned DefNumSets  = 2;
  localparam int unsigned DefNumWays  = 4;
  localparam int unsigned DefWordsPerLine = 2;
  localparam logic [7:0]  MissStallReset = 8'd30;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_RESP  = 2'd0,
    KIND_WBACK = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] fill_word_lo;
    logic [31:0] fill_word_hi;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] mem_address;
    logic [31:0] line_word_lo;
    logic [31:0] line_word_hi;
    logic [31:0] read_data;
    logic        was_hit;
    logic [7:0]  stall_cycles;
    logic        last;
  } rsp_t;

endpackage

// File: hw/rtl/sawlc_front.sv
// Front end: two-entry input queue that drops items the cache ignores.
// Depends on sawlc_pkg.
`timescale 1ns / 1ps
module sawlc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sawlc_pkg::req_t in_item_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output sawlc_pkg::req_t q_item_o
);
  import sawlc_pkg::*;

  // two-entry queue
  req_t        mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_stall_o = (cnt_q == 2'd2);
  // operation 3 causes nothing, drop it here
  assign push = in_valid_i && !in_stall_o && (in_item_i.operation != OP_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// File: hw/rtl/sawlc_back.sv
// Back end: tag lookup, LRU, write-back and fill handling, output register.
// Depends on sawlc_pkg. Geometry parameters are powers of two.
`timescale 1ns / 1ps
module sawlc_back #(
  parameter int unsigned NumSets      = sawlc_pkg::DefNumSets,
  parameter int unsigned NumWays      = sawlc_pkg::DefNumWays,
  parameter int unsigned WordsPerLine = sawlc_pkg::DefWordsPerLine
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      miss_stall_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  sawlc_pkg::req_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sawlc_pkg::rsp_t out_item_o
);
  import sawlc_pkg::*;

  localparam int unsigned SetW  = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned WayW  = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int unsigned WordW = (WordsPerLine > 1) ? $clog2(WordsPerLine) : 1;
  localparam int unsigned SetSh  = $clog2(NumSets);
  localparam int unsigned WordSh = $clog2(WordsPerLine);
  localparam int unsigned NumLines = NumSets * NumWays;
  localparam int unsigned LineW = (NumLines > 1) ? $clog2(NumLines) : 1;
  localparam int unsigned DataDepth = NumLines * WordsPerLine;
  localparam int unsigned DataW = (DataDepth > 1) ? $clog2(DataDepth) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_WBHI  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_FILL2 = 3'd5;

  logic [31:0] tag_q   [NumLines];
  logic [31:0] data_q  [DataDepth];
  logic        valid_q [NumLines];
  logic        dirty_q [NumLines];
  logic [WayW-1:0] rank_q [NumLines];

  logic [2:0]  st_q;
  req_t        cur_q;
  logic        busy_q, pend_wr_q;
  logic [31:0] pend_addr_q, pend_wd_q;
  logic [WayW-1:0] pend_way_q;
  logic [31:0] wb_addr_q, wb_lo_q;
  logic [31:0] fetch_addr_q;
  logic [31:0] fill_hi_q;
  logic        out_valid_q;
  rsp_t        out_q;

  // address split of the current access and of the pending miss
  logic [31:0] line_a, tag_a, fill_line;
  logic [SetW-1:0] set_a, set_p;
  logic [WordW-1:0] word_a, word_p;
  logic [31:0] tag_p;

  assign line_a = cur_q.address >> (2 + WordSh);
  assign word_a = (WordsPerLine > 1) ? WordW'(cur_q.address >> 2) : '0;
  assign set_a  = (NumSets > 1) ? SetW'(line_a) : '0;
  assign tag_a  = line_a >> SetSh;
  assign fill_line = pend_addr_q >> (2 + WordSh);
  assign word_p = (WordsPerLine > 1) ? WordW'(pend_addr_q >> 2) : '0;
  assign set_p  = (NumSets > 1) ? SetW'(fill_line) : '0;
  assign tag_p  = fill_line >> SetSh;

  logic            hit;
  logic [WayW-1:0] hit_way, victim;
  logic [LineW-1:0] hit_idx, vic_idx, fill_idx;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    victim = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (valid_q[LineW'(set_a * NumWays + w)]
          && tag_q[LineW'(set_a * NumWays + w)] == tag_a) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (rank_q[LineW'(set_a * NumWays + w)] == '0) victim = WayW'(w);
    end
  end

  assign hit_idx  = LineW'(set_a * NumWays + hit_way);
  assign vic_idx  = LineW'(set_a * NumWays + victim);
  assign fill_idx = LineW'(set_p * NumWays + pend_way_q);

  function automatic logic [DataW-1:0] didx(logic [LineW-1:0] l, logic [WordW-1:0] w);
    return DataW'(l * WordsPerLine + w);
  endfunction

  function automatic rsp_t mk_rsp(kind_e k, logic [31:0] a, logic [31:0] lo,
                                  logic [31:0] hi, logic [31:0] rd, logic hit_f,
                                  logic [7:0] st, logic lst);
    rsp_t r;
    r.kind = k;
    r.mem_address = a;
    r.line_word_lo = lo;
    r.line_word_hi = hi;
    r.read_data = rd;
    r.was_hit = hit_f;
    r.stall_cycles = st;
    r.last = lst;
    return r;
  endfunction

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;

  // a result enters the output register this cycle
  logic out_load;
  always_comb begin
    out_load = 1'b0;
    unique case (st_q)
      ST_LOOK: out_load = out_free && !busy_q && (cur_q.operation != OP_FILL)
                          && (hit || !(valid_q[vic_idx] && dirty_q[vic_idx]));
      ST_WBHI: out_load = 1'b1;
      ST_FETCH, ST_FILL2: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // LRU touch of a way in a set
  logic touch_en;
  logic [SetW-1:0] touch_set;
  logic [WayW-1:0] touch_way;
  always_comb begin
    touch_en = 1'b0;
    touch_set = set_a;
    touch_way = hit_way;
    if (st_q == ST_LOOK && out_free && (cur_q.operation == OP_READ
        || cur_q.operation == OP_WRITE) && !busy_q && hit) touch_en = 1'b1;
    if (st_q == ST_FILL2 && out_free) begin
      touch_en = 1'b1;
      touch_set = set_p;
      touch_way = pend_way_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLines; i++) rank_q[i] <= WayW'(i % NumWays);
    end else if (touch_en) begin
      for (int w = 0; w < NumWays; w++) begin
        if (rank_q[LineW'(touch_set * NumWays + w)] >
            rank_q[LineW'(touch_set * NumWays + touch_way)])
          rank_q[LineW'(touch_set * NumWays + w)] <=
            rank_q[LineW'(touch_set * NumWays + w)] - 1'b1;
      end
      rank_q[LineW'(touch_set * NumWays + touch_way)] <= WayW'(NumWays - 1);
    end
  end

  // data and tag memory plus pipeline registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (q_pop_o) cur_q <= q_item_i;
      ST_LOOK: begin
        if (out_free && !busy_q && hit && cur_q.operation == OP_WRITE)
          data_q[didx(hit_idx, word_a)] <= cur_q.write_data;
        if (out_free && !busy_q && !hit && (cur_q.operation == OP_READ
            || cur_q.operation == OP_WRITE)) begin
          pend_addr_q  <= cur_q.address;
          pend_wd_q    <= cur_q.write_data;
          pend_wr_q    <= (cur_q.operation == OP_WRITE);
          pend_way_q   <= victim;
          wb_addr_q    <= 32'(((tag_q[vic_idx] * NumSets + set_a) * WordsPerLine) << 2);
          wb_lo_q      <= data_q[didx(vic_idx, '0)];
          fetch_addr_q <= 32'(((tag_a * NumSets + set_a) * WordsPerLine) << 2);
        end
        if (out_free && busy_q && cur_q.operation == OP_FILL) fill_hi_q <= cur_q.fill_word_hi;
      end
      ST_FILL: begin
        data_q[didx(fill_idx, '0)] <= cur_q.fill_word_lo;
        tag_q[fill_idx] <= tag_p;
      end
      ST_FILL2: if (out_free) begin
        if (pend_wr_q) data_q[didx(fill_idx, word_p)] <= pend_wd_q;
      end
      default: ;
    endcase
    if (st_q == ST_FILL) begin
      for (int w = 1; w < WordsPerLine; w++)
        data_q[didx(fill_idx, WordW'(w))] <= (w == 1) ? fill_hi_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      for (int i = 0; i < NumLines; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (q_pop_o) st_q <= ST_LOOK;
        ST_LOOK: begin
          if (cur_q.operation == OP_FILL) begin
            if (!busy_q) st_q <= ST_IDLE;
            else if (out_free) st_q <= ST_FILL;
          end else if (busy_q) begin
            st_q <= ST_IDLE;
          end else if (out_free) begin
            if (hit) begin
              out_q <= mk_rsp(KIND_RESP, '0, '0, '0,
                              (cur_q.operation == OP_READ) ?
                                data_q[didx(hit_idx, word_a)] : '0,
                              1'b1, '0, 1'b1);
              if (cur_q.operation == OP_WRITE) dirty_q[hit_idx] <= 1'b1;
              st_q <= ST_IDLE;
            end else begin
              busy_q <= 1'b1;
              if (valid_q[vic_idx] && dirty_q[vic_idx]) begin
                dirty_q[vic_idx] <= 1'b0;
                st_q <= ST_WBHI;
              end else begin
                out_q <= mk_rsp(KIND_FETCH,
                                32'(((tag_a * NumSets + set_a) * WordsPerLine) << 2),
                                '0, '0, '0, 1'b0, '0, 1'b1);
                st_q <= ST_IDLE;
              end
            end
          end
        end
        ST_WBHI: begin
          out_q <= mk_rsp(KIND_WBACK, wb_addr_q, wb_lo_q,
                          (WordsPerLine > 1) ? data_q[didx(fill_idx, WordW'(1))] : '0,
                          '0, 1'b0, '0, 1'b0);
          st_q <= ST_FETCH;
        end
        ST_FETCH: if (out_free) begin
          out_q <= mk_rsp(KIND_FETCH, fetch_addr_q, '0, '0, '0, 1'b0, '0, 1'b1);
          st_q <= ST_IDLE;
        end
        ST_FILL: begin
          valid_q[fill_idx] <= 1'b1;
          dirty_q[fill_idx] <= 1'b0;
          st_q <= ST_FILL2;
        end
        ST_FILL2: if (out_free) begin
          out_q <= mk_rsp(KIND_RESP, '0, '0, '0,
                          pend_wr_q ? '0 : data_q[didx(fill_idx, word_p)],
                          1'b0, miss_stall_i, 1'b1);
          if (pend_wr_q) dirty_q[fill_idx] <= 1'b1;
          busy_q <= 1'b0;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/set_assoc_writeback_lru_cache_top.sv
// Top level of the set-associative write-back LRU cache.
// Instantiates sawlc_front and sawlc_back; uses sawlc_pkg.
//
// Usage: requests (read, write, fill) enter on the in channel with
// in_valid_i / in_stall_o; results leave on out_valid_o / out_stall_i.
// A read or write hit answers with one response item. A miss sends an
// optional write-back item of the dirty victim, then a fetch request with
// last set; the later fill item completes the access and yields the miss
// response carrying the configured stall count.
// Timing: the back end handles one item at a time, taking no new item until
// the last is through: a hit or clean miss goes through pop, then lookup;
// a dirty miss adds the write-back and fetch states; a fill adds the two
// fill states. A hit result is held in the output register.
// A two-entry queue between front and back accepts until full while the back
// end works or the receiver stalls; results wait in the output register.
// Reset clears valid and dirty bits and the queue and reloads LRU ranks.
// miss_stall_cycles resets to 30 and is written through the cfg channel,
// which is always ready. Geometry parameters are powers of two.
`timescale 1ns / 1ps
module set_assoc_writeback_lru_cache_top #(
  parameter int unsigned NumSets      = sawlc_pkg::DefNumSets,
  parameter int unsigned NumWays      = sawlc_pkg::DefNumWays,
  parameter int unsigned WordsPerLine = sawlc_pkg::DefWordsPerLine
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sawlc_pkg::req_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sawlc_pkg::rsp_t out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_data_i
);
  import sawlc_pkg::*;

  logic [7:0] miss_stall_q;
  logic       q_valid, q_pop;
  req_t       q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) miss_stall_q <= MissStallReset;
    else if (cfg_valid_i) miss_stall_q <= cfg_data_i;
  end

  sawlc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  sawlc_back #(
    .NumSets(NumSets), .NumWays(NumWays), .WordsPerLine(WordsPerLine)
  ) u_back (
    .clk_i, .rst_ni, .miss_stall_i(miss_stall_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .out_item_o
  );
endmodule

// File: dv/testbench.sv
// Testbench for the set-associative write-back LRU cache top level.
// Self-contained: drives the request channel, predicts results and checks them; uses sawlc_pkg.
`timescale 1ns / 1ps
module testbench;
  import sawlc_pkg::*;

  localparam int unsigned Sets  = DefNumSets;
  localparam int unsigned Ways  = DefNumWays;
  localparam int unsigned Words = DefWordsPerLine;
  localparam int unsigned Lines = Sets * Ways;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  req_t       in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rsp_t       out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  set_assoc_writeback_lru_cache_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow cache state
  logic [31:0] shadow_data [Lines*Words];
  logic [27:0] shadow_tag  [Lines];
  logic        shadow_valid[Lines];
  logic        shadow_dirty[Lines];
  logic [1:0]  shadow_rank [Lines];
  logic        miss_open;
  logic        miss_write;
  int unsigned miss_way;
  logic [31:0] miss_addr;
  logic [31:0] miss_wdata;
  logic [7:0]  stall_setting;

  req_t pending_items[$];
  rsp_t expected_rsps[$];
  int   mismatches = 0;
  int   src_idle_pct = 0;
  int   dst_idle_pct = 0;
  bit   hold_sender = 1'b0;

  function automatic rsp_t make_rsp(kind_e k, logic [31:0] a, logic [31:0] lo,
                                    logic [31:0] hi, logic [31:0] rd, logic hit,
                                    logic [7:0] st, logic lst);
    rsp_t r;
    r.kind = k; r.mem_address = a; r.line_word_lo = lo; r.line_word_hi = hi;
    r.read_data = rd; r.was_hit = hit; r.stall_cycles = st; r.last = lst;
    return r;
  endfunction

  function automatic void touch_way(int unsigned set, int unsigned way);
    logic [1:0] r;
    r = shadow_rank[set*Ways + way];
    for (int w = 0; w < Ways; w++)
      if (shadow_rank[set*Ways + w] > r) shadow_rank[set*Ways + w]--;
    shadow_rank[set*Ways + way] = 2'(Ways - 1);
  endfunction

  function automatic logic [31:0] line_addr(logic [27:0] tag, int unsigned set);
    return 32'((tag * Sets + set) * Words * 4);
  endfunction

  // Applies one accepted request to the shadow cache and queues its results.
  function automatic void predict_cache(req_t it);
    int unsigned set, word, idx, victim;
    logic [27:0] tag;
    logic [31:0] rd;
    logic        found;
    rd = '0;
    found = 1'b0;
    if (it.operation == OP_READ || it.operation == OP_WRITE) begin
      if (miss_open) return;
      word = (it.address >> 2) % Words;
      set  = ((it.address >> 2) / Words) % Sets;
      tag  = 28'(((it.address >> 2) / Words) / Sets);
      for (int w = 0; w < Ways; w++) begin
        idx = set*Ways + w;
        if (!found && shadow_valid[idx] && shadow_tag[idx] == tag) begin
          found = 1'b1;
          touch_way(set, w);
          if (it.operation == OP_WRITE) begin
            shadow_data[idx*Words + word] = it.write_data;
            shadow_dirty[idx] = 1'b1;
          end else rd = shadow_data[idx*Words + word];
          expected_rsps.push_back(make_rsp(KIND_RESP, '0, '0, '0, rd, 1'b1, '0, 1'b1));
        end
      end
      if (found) return;
      victim = 0;
      for (int w = Ways - 1; w >= 0; w--)
        if (shadow_rank[set*Ways + w] == 0) victim = w;
      idx = set*Ways + victim;
      if (shadow_valid[idx] && shadow_dirty[idx]) begin
        expected_rsps.push_back(make_rsp(KIND_WBACK, line_addr(shadow_tag[idx], set),
          shadow_data[idx*Words], shadow_data[idx*Words + 1], '0, 1'b0, '0, 1'b0));
        shadow_dirty[idx] = 1'b0;
      end
      expected_rsps.push_back(make_rsp(KIND_FETCH, line_addr(tag, set), '0, '0, '0,
                                       1'b0, '0, 1'b1));
      miss_open = 1'b1;
      miss_write = (it.operation == OP_WRITE);
      miss_way = victim;
      miss_addr = it.address;
      miss_wdata = it.write_data;
    end else if (it.operation == OP_FILL && miss_open) begin
      word = (miss_addr >> 2) % Words;
      set  = ((miss_addr >> 2) / Words) % Sets;
      tag  = 28'(((miss_addr >> 2) / Words) / Sets);
      idx  = set*Ways + miss_way;
      shadow_data[idx*Words]     = it.fill_word_lo;
      shadow_data[idx*Words + 1] = it.fill_word_hi;
      shadow_tag[idx] = tag;
      shadow_valid[idx] = 1'b1;
      shadow_dirty[idx] = 1'b0;
      touch_way(set, miss_way);
      if (miss_write) begin
        shadow_data[idx*Words + word] = miss_wdata;
        shadow_dirty[idx] = 1'b1;
      end else rd = shadow_data[idx*Words + word];
      miss_open = 1'b0;
      expected_rsps.push_back(make_rsp(KIND_RESP, '0, '0, '0, rd, 1'b0, stall_setting, 1'b1));
    end
  endfunction

  // Driver: valid is independent of stall; payload holds while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && !hold_sender &&
            $urandom_range(99) >= src_idle_pct) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  // Monitor: predict on accepted requests, compare accepted results.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_cache(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item_o);
        end else begin
          want = expected_rsps.pop_front();
          if (out_item_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_item_o);
          end
        end
      end
    end
  end

  function automatic req_t mk_req(op_e op, logic [31:0] a, logic [31:0] wd,
                                  logic [31:0] lo, logic [31:0] hi);
    req_t r;
    r.operation = op; r.address = a; r.write_data = wd;
    r.fill_word_lo = lo; r.fill_word_hi = hi;
    return r;
  endfunction

  // Address from a small tag pool so hits and evictions both happen often.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(3) != 0) a[31:4] = 28'($urandom_range(11)) ^ {28{a[31]}};
    return a;
  endfunction

  // Access always followed by a fill, whether the access hits or misses.
  task automatic add_access(op_e op, logic [31:0] a);
    pending_items.push_back(mk_req(op, a, $urandom, $urandom, $urandom));
    pending_items.push_back(mk_req(OP_FILL, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic wait_drain();
    while (pending_items.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_stall(logic [7:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    stall_setting = v;
  endtask

  // Note: every access is followed by a fill. If the access hit, the fill is
  // ignored; if it missed, it completes it. So no read ever sees unwritten data.
  initial begin
    int n;
    for (int i = 0; i < Lines; i++) begin
      shadow_valid[i] = 1'b0; shadow_dirty[i] = 1'b0; shadow_tag[i] = '0;
      shadow_rank[i] = 2'(i % Ways);
      shadow_data[i*Words] = '0; shadow_data[i*Words + 1] = '0;
    end
    miss_open = 1'b0; miss_write = 1'b0; miss_way = 0;
    miss_addr = '0; miss_wdata = '0;
    stall_setting = MissStallReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: reset stall value, then extremes of every field.
    pending_items.push_back(mk_req(OP_FILL, '1, '1, '1, '1));        // fill while idle
    pending_items.push_back(mk_req(OP_NONE, '1, '1, '1, '1));        // operation 3
    pending_items.push_back(mk_req(OP_READ, 32'h0, '0, '0, '0));     // tag 0 must miss
    pending_items.push_back(mk_req(OP_READ, 32'h4, '0, '0, '0));     // access while miss open
    pending_items.push_back(mk_req(OP_FILL, '0, '0, 32'h0, 32'hffffffff));
    pending_items.push_back(mk_req(OP_READ, 32'h4, '0, '0, '0));     // hit
    pending_items.push_back(mk_req(OP_WRITE, 32'h0, '1, '0, '0));    // write hit
    pending_items.push_back(mk_req(OP_WRITE, '1, 32'ha5a5a5a5, '0, '0));
    pending_items.push_back(mk_req(OP_FILL, '0, '0, '1, '0));
    for (int t = 1; t <= 4; t++) add_access(OP_WRITE, {28'(t), 4'h0}); // evict dirty
    add_access(OP_READ, 32'h0);
    wait_drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_stall((ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom));
      src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 45 : 0;
      dst_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 15 : 0;
      for (int k = 0; k < 150; k++) begin
        n = $urandom_range(19);
        if (n == 0)
          pending_items.push_back(mk_req(op_e'($urandom_range(3)), $urandom, $urandom,
                                         $urandom, $urandom));
        else
          add_access($urandom_range(1) ? OP_WRITE : OP_READ, pick_addr());
      end
      if (ph == 1) begin
        // hold the sender until every expected result is back
        while (pending_items.size() > 150) @(posedge clk_i);
        hold_sender = 1'b1;
        while (in_valid_i || expected_rsps.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drain();
    end
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
